@@ design/lsss_pkg.sv @@
// Shared types and constants for the level-set sphere speed block.
// Used by lsss_cfg and level_set_sphere_speed.
// No dependencies.
package lsss_pkg;

    // One in Q16.16.
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    // Settle threshold: 0.0001 truncated to Q16.16.
    localparam logic [15:0] EPS_Q16 = 16'd6;
    // Largest offset magnitude kept per axis.
    localparam logic [34:0] OFS_CLAMP = 35'h080000000;
    // Reset value of the radius register (1.0).
    localparam logic [30:0] RADIUS_RESET = 31'h0001_0000;

    // Register indexes of the configuration port (byte address / 4).
    typedef enum logic [2:0] {
        REG_CENTRE_X  = 3'd0,
        REG_CENTRE_Y  = 3'd1,
        REG_CENTRE_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_DIRECTION = 3'd4
    } t_reg_idx;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
        logic [30:0]        radius;
        logic               direction;
    } t_cfg;

endpackage

@@ design/lsss_cfg.sv @@
// Configuration register file with an APB-style access port.
// Depends on lsss_pkg for the register indexes and the t_cfg struct.
module lsss_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lsss_pkg::t_cfg    o_cfg
);

    lsss_pkg::t_cfg   r_cfg;
    lsss_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = lsss_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_x  <= '0;
            r_cfg.centre_y  <= '0;
            r_cfg.centre_z  <= '0;
            r_cfg.radius    <= lsss_pkg::RADIUS_RESET;
            r_cfg.direction <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                lsss_pkg::REG_CENTRE_X:  r_cfg.centre_x  <= pwdata;
                lsss_pkg::REG_CENTRE_Y:  r_cfg.centre_y  <= pwdata;
                lsss_pkg::REG_CENTRE_Z:  r_cfg.centre_z  <= pwdata;
                lsss_pkg::REG_RADIUS:    r_cfg.radius    <= pwdata[30:0];
                lsss_pkg::REG_DIRECTION: r_cfg.direction <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lsss_pkg::REG_CENTRE_X:  prdata = r_cfg.centre_x;
            lsss_pkg::REG_CENTRE_Y:  prdata = r_cfg.centre_y;
            lsss_pkg::REG_CENTRE_Z:  prdata = r_cfg.centre_z;
            lsss_pkg::REG_RADIUS:    prdata = {1'b0, r_cfg.radius};
            lsss_pkg::REG_DIRECTION: prdata = {31'b0, r_cfg.direction};
            default:                 prdata = '0;
        endcase
    end

endmodule

@@ design/lsss_isqrt.sv @@
// Bit-serial floor square root of a 64-bit operand, one result bit per cycle.
// No package dependencies.
module lsss_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_b;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_trial;

    assign w_trial = r_r + r_b;
    assign o_done  = r_done;
    assign o_root  = r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_rad;
                r_r    <= '0;
                r_b    <= 64'h4000_0000_0000_0000;
                r_cnt  <= 5'd31;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= w_trial) begin
                    r_v <= r_v - w_trial;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/lsss_div.sv @@
// Restoring divider: 64-bit dividend by 32-bit divisor, 17 quotient bits,
// one bit per cycle, with an overflow flag for quotients of 2^17 or more.
module lsss_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic        o_ovf,
    output logic [16:0] o_quot
);

    logic [31:0] r_rem;
    logic [16:0] r_low;
    logic [16:0] r_q;
    logic [31:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_ovf;
    logic [32:0] w_trial;
    logic        w_fit;
    logic        w_ovf;

    assign w_trial = {r_rem, r_low[16]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});
    assign w_ovf   = (i_dividend[63:17] >= {15'b0, i_divisor});
    assign o_done  = r_done;
    assign o_ovf   = r_ovf;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvs <= i_divisor;
                r_rem <= i_dividend[48:17];
                r_low <= i_dividend[16:0];
                r_q   <= '0;
                r_cnt <= 5'd16;
                r_ovf <= w_ovf;
                if (w_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= 32'(w_trial - {1'b0, r_dvs});
                end else begin
                    r_rem <= w_trial[31:0];
                end
                r_q   <= {r_q[15:0], w_fit};
                r_low <= {r_low[15:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/level_set_sphere_speed.sv @@
// Top level of the level-set sphere speed block: sequencer, shared multiplier,
// output register. Depends on lsss_pkg, lsss_cfg, lsss_isqrt and lsss_div.
//
// For each grid point word this block returns the surface speed toward (attract)
// or away from (repel) a configured sphere, plus a pass-wide flag that stays
// high while every point since the last pass start asked for a move of at most
// 6 LSB (0.0001 in Q16.16). One point is processed at a time: s_axis_tready is
// high only while the sequencer is idle. A point with a zero gradient skips the
// gradient square root and the three normal divisions; a point on or outside
// the sphere skips the impulse division. The work is done by the bit-serial
// square root (run once for the gradient length and once for the distance) and
// the bit-serial divider (used three times for the normal and once for the
// impulse), with one shared 32x32 multiplier forming the products. The result
// waits in an output register, so the next point is taken while the previous
// speed has not yet been read; a second result waits in the output step until
// the register is free. The user must write the registers over the APB-style
// port only while idle; the block itself does not enforce this.
module level_set_sphere_speed #(
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input point word.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], grad_x[79:48],
    // grad_y[111:80], grad_z[143:112], level_value[175:144]
    input  logic [175:0] s_axis_tdata,
    // pass_start[0]
    input  logic [0:0]   s_axis_tuser,
    // Result word.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // speed[16:0], zero fill [23:17]
    output logic [23:0]  m_axis_tdata,
    // pass_complete[0]
    output logic [0:0]   m_axis_tuser,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_GM, S_GA, S_GQ, S_GS, S_NST, S_ND, S_NM, S_NS,
        S_DM, S_DA, S_DQ, S_DS, S_MM, S_MST, S_MW, S_OUT
    } t_state;

    t_state              r_state;
    logic [1:0]          r_idx;
    logic signed [15:0]  r_pos [3];
    logic signed [31:0]  r_grad [3];
    logic signed [31:0]  r_lv;
    logic signed [33:0]  r_s [3];
    logic [63:0]         r_acc;
    logic [63:0]         r_prod;
    logic [31:0]         r_g;
    logic [16:0]         r_n;
    logic [31:0]         r_nrm;
    logic [16:0]         r_m;
    logic                r_flag;
    logic                r_out_valid;
    logic [16:0]         r_out_speed;
    logic                r_out_flag;

    lsss_pkg::t_cfg      w_cfg;
    logic                w_in_acc;
    logic                w_gzero;
    logic [31:0]         w_gmag;
    logic [31:0]         w_lmag;
    logic signed [31:0]  w_centre;
    logic signed [34:0]  w_d;
    logic [34:0]         w_dabs;
    logic [31:0]         w_dmag;
    logic [31:0]         w_mul_a;
    logic [31:0]         w_mul_b;
    logic [63:0]         w_mul_p;
    logic [31:0]         w_t;
    logic signed [33:0]  w_ps;
    logic signed [33:0]  w_s;
    logic                w_sq_start;
    logic [63:0]         w_sq_rad;
    logic                w_sq_done;
    logic [31:0]         w_sq_root;
    logic                w_dv_start;
    logic [63:0]         w_dv_dividend;
    logic [31:0]         w_dv_divisor;
    logic                w_dv_done;
    logic                w_dv_ovf;
    logic [16:0]         w_dv_quot;
    logic [15:0]         w_h;
    logic                w_flag_next;
    logic                w_out_free;

    lsss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lsss_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_sq_rad),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    lsss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dv_start),
        .i_dividend (w_dv_dividend),
        .i_divisor  (w_dv_divisor),
        .o_done     (w_dv_done),
        .o_ovf      (w_dv_ovf),
        .o_quot     (w_dv_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_gzero       = (s_axis_tdata[79:48] == '0) && (s_axis_tdata[111:80] == '0)
                           && (s_axis_tdata[143:112] == '0);

    // Magnitudes; negating the most negative value still gives 2^31 unsigned.
    assign w_gmag = r_grad[r_idx][31] ? 32'(-r_grad[r_idx]) : 32'(r_grad[r_idx]);
    assign w_lmag = r_lv[31] ? 32'(-r_lv) : 32'(r_lv);

    always_comb begin
        case (r_idx)
            2'd0:    w_centre = w_cfg.centre_x;
            2'd1:    w_centre = w_cfg.centre_y;
            default: w_centre = w_cfg.centre_z;
        endcase
    end

    // Offset from the surface point to the centre, magnitude held to 2^31.
    assign w_d    = 35'(w_centre) - 35'(r_s[r_idx]);
    assign w_dabs = w_d[34] ? 35'(-w_d) : 35'(w_d);
    assign w_dmag = (w_dabs > lsss_pkg::OFS_CLAMP) ? lsss_pkg::OFS_CLAMP[31:0]
                                                   : w_dabs[31:0];

    // Shared multiplier operand selection.
    always_comb begin
        case (r_state)
            S_GM: begin
                w_mul_a = w_gmag;
                w_mul_b = w_gmag;
            end
            S_NM: begin
                w_mul_a = {15'b0, r_n};
                w_mul_b = w_lmag;
            end
            S_MM: begin
                w_mul_a = r_g;
                w_mul_b = {1'b0, w_cfg.radius - r_nrm[30:0]};
            end
            default: begin
                w_mul_a = w_dmag;
                w_mul_b = w_dmag;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // Surface point along the normal: pos - sign * t.
    assign w_t  = r_prod[47:16];
    assign w_ps = {{2{r_pos[r_idx][15]}}, r_pos[r_idx], 16'b0};
    assign w_s  = (r_grad[r_idx][31] != r_lv[31]) ? w_ps + {2'b0, w_t}
                                                   : w_ps - {2'b0, w_t};

    assign w_sq_start = (r_state == S_GQ) || (r_state == S_DQ);
    assign w_sq_rad   = r_acc;

    assign w_dv_start = (r_state == S_NST) || (r_state == S_MST);
    always_comb begin
        if (r_state == S_MST) begin
            w_dv_dividend = r_prod;
            w_dv_divisor  = {1'b0, w_cfg.radius};
        end else begin
            w_dv_dividend = {16'b0, w_gmag, 16'b0};
            w_dv_divisor  = r_g;
        end
    end

    assign w_h         = r_m[16:1];
    assign w_flag_next = r_flag & (w_h <= lsss_pkg::EPS_Q16);
    assign w_out_free  = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_speed};
    assign m_axis_tuser  = r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_flag      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // The output step reloads the register itself when it is taken.
            if (r_out_valid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_pos[0]  <= s_axis_tdata[15:0];
                        r_pos[1]  <= s_axis_tdata[31:16];
                        r_pos[2]  <= s_axis_tdata[47:32];
                        r_grad[0] <= s_axis_tdata[79:48];
                        r_grad[1] <= s_axis_tdata[111:80];
                        r_grad[2] <= s_axis_tdata[143:112];
                        r_lv      <= s_axis_tdata[175:144];
                        r_idx     <= '0;
                        r_acc     <= '0;
                        if (s_axis_tuser[0]) begin
                            r_flag <= 1'b1;
                        end
                        if (w_gzero) begin
                            // No gradient: the point stays where it is, G is one.
                            r_g     <= {15'b0, lsss_pkg::ONE_Q16};
                            r_s[0]  <= {{2{s_axis_tdata[15]}}, s_axis_tdata[15:0], 16'b0};
                            r_s[1]  <= {{2{s_axis_tdata[31]}}, s_axis_tdata[31:16], 16'b0};
                            r_s[2]  <= {{2{s_axis_tdata[47]}}, s_axis_tdata[47:32], 16'b0};
                            r_state <= S_DM;
                        end else begin
                            r_state <= S_GM;
                        end
                    end
                end
                S_GM: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_GA;
                end
                S_GA: begin
                    r_acc <= r_acc + r_prod;
                    if (r_idx == 2'd2) begin
                        r_state <= S_GQ;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_GM;
                    end
                end
                S_GQ: begin
                    r_state <= S_GS;
                end
                S_GS: begin
                    if (w_sq_done) begin
                        r_g     <= w_sq_root;
                        r_idx   <= '0;
                        r_state <= S_NST;
                    end
                end
                S_NST: begin
                    r_state <= S_ND;
                end
                S_ND: begin
                    if (w_dv_done) begin
                        // |g_i| never exceeds G, so the normal stays at or below one.
                        r_n     <= w_dv_quot;
                        r_state <= S_NM;
                    end
                end
                S_NM: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_NS;
                end
                S_NS: begin
                    r_s[r_idx] <= w_s;
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= S_DM;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_NST;
                    end
                end
                S_DM: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_DA;
                end
                S_DA: begin
                    r_acc <= r_acc + r_prod;
                    if (r_idx == 2'd2) begin
                        r_state <= S_DQ;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_DM;
                    end
                end
                S_DQ: begin
                    r_state <= S_DS;
                end
                S_DS: begin
                    if (w_sq_done) begin
                        r_nrm <= w_sq_root;
                        if (w_sq_root >= {1'b0, w_cfg.radius}) begin
                            r_m     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MM;
                        end
                    end
                end
                S_MM: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_MST;
                end
                S_MST: begin
                    r_state <= S_MW;
                end
                S_MW: begin
                    if (w_dv_done) begin
                        if (w_dv_ovf || (w_dv_quot > lsss_pkg::ONE_Q16)) begin
                            r_m <= lsss_pkg::ONE_Q16;
                        end else begin
                            r_m <= w_dv_quot;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_speed <= w_cfg.direction ? {1'b0, w_h} : 17'(-{1'b0, w_h});
                        r_out_flag  <= w_flag_next;
                        r_flag      <= w_flag_next;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != S_IDLE)
        else $error("sequencer stayed idle after taking a point");

    a_norm_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ND && w_dv_done) |-> !w_dv_ovf)
        else $error("normal component division overflowed");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the output step");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_GS || r_state == S_DS))
        else $error("square root finished while the sequencer was not waiting");
`endif

endmodule
